[src/assert_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define SPNG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spng assertion failed");

// Check that the consequent holds in the same cycle as the antecedent, outside reset.
`define SPNG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spng assertion failed");

// Check the cycle after the antecedent, including the reset cycles themselves.
`define SPNG_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("spng assertion failed");

`endif

[src/spng_pkg.sv]
// Types and constants of the sine PWM note generator.
`default_nettype none

package spng_pkg;

   // Request codes
   localparam logic [1:0] REQ_NOTE       = 2'd0;
   localparam logic [1:0] REQ_PERIOD_END = 2'd1;
   localparam logic [1:0] REQ_TICK       = 2'd2;

   localparam int NUMER_W    = 23;
   localparam int FREQ_W     = 16;
   localparam int REPEAT_W   = 8;
   localparam int PERIOD_W   = 16;
   localparam int SAMPLE_W   = 10;
   localparam int INDEX_W    = 5;
   localparam int TICK_W     = 9;
   localparam int DIVIDEND_W = 26;
   localparam int ROM_DEPTH  = 32;

   localparam int DIV_STEPS = DIVIDEND_W;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic [NUMER_W-1:0]  NUMERATOR_RESET = 23'd5000000;
   localparam logic [PERIOD_W-1:0] DUTY_SCALE      = 16'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 16'hFFFF;

   // One full sine cycle, scaled to 1..999
   localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
      10'd500, 10'd598, 10'd691, 10'd778, 10'd854, 10'd916, 10'd962, 10'd990,
      10'd999, 10'd990, 10'd962, 10'd916, 10'd854, 10'd778, 10'd691, 10'd598,
      10'd500, 10'd402, 10'd309, 10'd222, 10'd146, 10'd84,  10'd38,  10'd10,
      10'd1,   10'd10,  10'd38,  10'd84,  10'd146, 10'd222, 10'd309, 10'd402
   };

   typedef struct packed {
      logic [1:0]          req_type;
      logic [FREQ_W-1:0]   note_frequency;
      logic [REPEAT_W-1:0] repeat_count;
   } req_payload_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] pwm_period;
      logic [PERIOD_W-1:0] pwm_compare;
      logic                output_enabled;
      logic [INDEX_W-1:0]  sample_index;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic commit;
   } spng_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic playing;
   } spng_status_type;

endpackage

`default_nettype wire

[src/spng_ctrl.sv]
// Sequencing state machine of the sine PWM note generator.
`default_nettype none

module spng_ctrl
   import spng_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire logic [1:0]      req_code,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      spng_cmd_type    cmd,
   input  wire spng_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_code == REQ_NOTE ||
                   (req_code == REQ_PERIOD_END && status.playing)) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // commit only once the previous result has left
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/spng_datapath.sv]
// Datapath of the sine PWM note generator: playback state, multiplier, shared divider.
`default_nettype none

module spng_datapath
   import spng_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_payload,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_write_enable,
   input  wire logic [NUMER_W-1:0] csr_write_data,
   input  wire spng_cmd_type    cmd,
   output      spng_status_type status
);

   localparam int PosW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [PosW-1:0] POS_LAST = PosW'(TABLE_DEPTH - 1);

   // Playback state
   logic [NUMER_W-1:0]  numer_ff, numer_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] compare_ff, compare_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [REPEAT_W-1:0] limit_ff, limit_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic                playing_ff, playing_in;

   // Held transaction and divider
   req_payload_type       item_ff;
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [PERIOD_W-1:0]   rem_ff;
   logic [PERIOD_W-1:0]   divisor_ff;

   logic [SAMPLE_W-1:0]   pos_sample [TABLE_DEPTH];
   logic [SAMPLE_W-1:0]   sample;
   logic [DIVIDEND_W-1:0] product;
   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     diff;
   logic                  fits;
   logic [PERIOD_W-1:0]   period_sat;

   // Position-to-sample table, resolved at elaboration
   for (genvar p = 0; p < TABLE_DEPTH; p++) begin : g_lut
      assign pos_sample[p] = SINE_ROM[(p * ROM_DEPTH) / TABLE_DEPTH];
   end

   assign sample  = pos_sample[pos_ff];
   assign product = DIVIDEND_W'(sample * period_ff);

   // Restoring divider, one quotient bit per step
   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   assign period_sat = (|quot_ff[DIVIDEND_W-1:PERIOD_W]) ? PERIOD_MAX
                                                       : quot_ff[PERIOD_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
         rem_ff  <= '0;
         if (req_payload.req_type == REQ_NOTE) begin
            quot_ff    <= DIVIDEND_W'(numer_ff);
            divisor_ff <= req_payload.note_frequency;
         end else begin
            quot_ff    <= product;
            divisor_ff <= DUTY_SCALE;
         end
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
      end
   end

   always_comb begin
      numer_in   = csr_write_enable ? csr_write_data : numer_ff;
      period_in  = period_ff;
      compare_in = compare_ff;
      pos_in     = pos_ff;
      limit_in   = limit_ff;
      tick_in    = tick_ff;
      playing_in = playing_ff;
      if (cmd.commit) begin
         unique case (item_ff.req_type)
            REQ_NOTE: begin
               period_in  = period_sat;
               limit_in   = item_ff.repeat_count;
               playing_in = 1'b1;
            end
            REQ_PERIOD_END: begin
               if (playing_ff) begin
                  compare_in = quot_ff[PERIOD_W-1:0];
                  pos_in     = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
               end
            end
            REQ_TICK: begin
               if (playing_ff) begin
                  // stop once the count has passed the repeat limit
                  if (tick_ff > {1'b0, limit_ff}) begin
                     playing_in = 1'b0;
                     tick_in    = '0;
                  end else begin
                     tick_in = tick_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         numer_ff   <= NUMERATOR_RESET;
         period_ff  <= '0;
         compare_ff <= '0;
         pos_ff     <= '0;
         limit_ff   <= '0;
         tick_ff    <= '0;
         playing_ff <= 1'b0;
      end else begin
         numer_ff   <= numer_in;
         period_ff  <= period_in;
         compare_ff <= compare_in;
         pos_ff     <= pos_in;
         limit_ff   <= limit_in;
         tick_ff    <= tick_in;
         playing_ff <= playing_in;
      end
   end

   assign rsp_payload.pwm_period     = period_ff;
   assign rsp_payload.pwm_compare    = compare_ff;
   assign rsp_payload.output_enabled = playing_ff;
   assign rsp_payload.sample_index   = INDEX_W'(pos_ff);

   assign status.playing = playing_ff;

endmodule

`default_nettype wire

[src/sine_pwm_note_generator_core.sv]
// Top level of the sine PWM note generator.
`default_nettype none

// Sine PWM note generator. Each request transaction is one event: a note
// request (new frequency word and repeat count), a PWM period end, or a
// duration tick; every transaction yields exactly one result transaction that
// reports the period, duty compare, play flag and next sine table position as
// they stand after the event. A note request sets the period to
// period_numerator / note_frequency, saturated to 65535 (also for a zero
// frequency). A period end while playing loads the compare with
// sine * period / 1000 and steps the table position. A duration tick while
// playing counts, and stops playback once the count has passed the repeat
// count. Note requests and period ends while playing pass from acceptance
// to result through a load step (the 10x16 sine multiply happens here),
// the shared restoring divider that produces one quotient bit per cycle,
// and a commit step that waits while an earlier result is still stalled.
// Other requests skip the divider. The block holds one transaction at a time;
// req_stall is high from acceptance until commit, and a new request is
// taken the cycle after commit even while the result is still stalled.
// The result lives in the playback registers themselves, which change only
// at commit, so a stalled result holds. The period numerator may be written
// on the csr port whenever no transaction is in flight.
module sine_pwm_note_generator_core
   import spng_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire req_payload_type    req_payload,
   // result channel
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      rsp_payload_type    rsp_payload,
   // period numerator register
   input  wire logic               csr_write_enable,
   input  wire logic [NUMER_W-1:0] csr_write_data
);

   spng_cmd_type    cmd;
   spng_status_type status;

   // Sequencer: accept, run the divider, commit
   spng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_code  (req_payload.req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Playback registers, multiplier and divider
   spng_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

[src/spng_checker.sv]
// Port-level checker of the sine PWM note generator and its bind.
`default_nettype none

`include "assert_macros.svh"

module spng_checker
   import spng_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // hold a stalled result
   `SPNG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // one transaction at a time: stall right after acceptance
   `SPNG_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)

   // playback only starts together with a new result
   `SPNG_ASSERT_NOW(a_play_start, $rose(rsp_payload.output_enabled), rsp_valid)

   // reset drops the result and stops playback
   `SPNG_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_valid && !rsp_payload.output_enabled)

endmodule

bind sine_pwm_note_generator_core spng_checker u_spng_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
